/* hdl/assert_macros.svh */
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TDOR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TDOR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TDOR_ASSERT_IMP(lbl, ante, cons)
`define TDOR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/tdor_pkg.sv */
package tdor_pkg;

  localparam int NODE_W        = 16;
  localparam int DIG_BITS      = 7;
  localparam int HOP_DIM_BITS  = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam int DEF_N_DIMS    = 3;
  localparam int DEF_NODE_BITS = 16;

  // register indexes, dimension lengths follow own node in order
  localparam logic [CFG_IDX_BITS-1:0] REG_OWN_NODE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_LEN_0 = 3'd1;

  typedef struct packed {
    logic [HOP_DIM_BITS-1:0] hop_dim;
    logic                    hop_plus;
    logic                    arrived;
    logic                    no_route;
  } route_flags_t;

endpackage

/* hdl/tdor_if.sv */
interface tdor_in_if;
  logic                          valid;
  logic                          ready;
  logic [tdor_pkg::NODE_W-1:0]   dest_node;

  modport source (output valid, output dest_node, input ready);
  modport sink   (input valid, input dest_node, output ready);
endinterface

interface tdor_out_if;
  logic                                valid;
  logic                                ready;
  logic [tdor_pkg::NODE_W-1:0]         next_node;
  logic [tdor_pkg::HOP_DIM_BITS-1:0]   hop_dim;
  logic                                hop_plus;
  logic                                arrived;
  logic                                no_route;

  modport source (output valid, output next_node, output hop_dim, output hop_plus,
                  output arrived, output no_route, input ready);
  modport sink   (input valid, input next_node, input hop_dim, input hop_plus,
                  input arrived, input no_route, output ready);
endinterface

/* hdl/torus_dimension_order_route.sv */
// channel   dir   handshake          payload
// in_ch     in    valid / ready      dest_node
// out_ch    out   valid / ready      next_node, hop_dim, hop_plus, arrived, no_route
// cfg_*     in    cfg_we             cfg_index, cfg_wdata
//
// one item per cycle while out_ch.ready holds; each item passes through the
// one-bit-per-cell division chain that splits both node numbers into
// coordinates, then the route cell and one join cell per dimension.
// rst_n is synchronous: empties every cell, own_node to 0, lengths to 1.
// every cell takes an item when empty or when its neighbor takes its own, so
// items keep entering while a result waits at the output, until every cell is full.
`include "assert_macros.svh"

module torus_dimension_order_route #(
  parameter int N_DIMS    = tdor_pkg::DEF_N_DIMS,
  parameter int NODE_BITS = tdor_pkg::DEF_NODE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  tdor_in_if.sink                                in_ch,
  tdor_out_if.source                             out_ch,
  input  logic                                   cfg_we,
  input  logic [tdor_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [tdor_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

  localparam int NW       = tdor_pkg::NODE_W;
  localparam int DIG      = tdor_pkg::DIG_BITS;
  localparam int HDB      = tdor_pkg::HOP_DIM_BITS;
  localparam int CIB      = tdor_pkg::CFG_IDX_BITS;
  localparam int VAL_BITS = (NODE_BITS < NW) ? NODE_BITS : NW;
  localparam int NUM_DIV  = N_DIMS * VAL_BITS;

  logic [VAL_BITS-1:0]           own_node_r;
  logic [N_DIMS-1:0][DIG-1:0]    dim_len_r;
  logic [N_DIMS-1:0][DIG-1:0]    eff_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_node_r <= '0;
      for (int k = 0; k < N_DIMS; k++) begin
        dim_len_r[k] <= DIG'(1);
      end
    end else if (cfg_we) begin
      if (cfg_index == tdor_pkg::REG_OWN_NODE) begin
        own_node_r <= cfg_wdata[VAL_BITS-1:0];
      end
      for (int k = 0; k < N_DIMS; k++) begin
        if (cfg_index == CIB'(tdor_pkg::REG_DIM_LEN_0 + k)) begin
          dim_len_r[k] <= cfg_wdata[DIG-1:0];
        end
      end
    end
  end

  // a length of zero acts as one
  always_comb begin
    for (int k = 0; k < N_DIMS; k++) begin
      eff_len[k] = (dim_len_r[k] == '0) ? DIG'(1) : dim_len_r[k];
    end
  end

  // division chain
  logic [NUM_DIV:0]                              dv_valid;
  logic [NUM_DIV:0]                              dv_ready;
  logic [NUM_DIV:0][1:0][VAL_BITS-1:0]           dv_dq;
  logic [NUM_DIV:0][1:0][DIG-1:0]                dv_rem;
  logic [NUM_DIV:0][1:0][N_DIMS-1:0][DIG-1:0]    dv_dig;

  assign dv_valid[0]  = in_ch.valid;
  assign in_ch.ready  = dv_ready[0];
  assign dv_dq[0][0]  = own_node_r;
  assign dv_dq[0][1]  = in_ch.dest_node[VAL_BITS-1:0];
  assign dv_rem[0]    = '0;
  assign dv_dig[0]    = '0;

  for (genvar s = 0; s < NUM_DIV; s++) begin : g_div
    localparam int DIM  = s / VAL_BITS;
    localparam bit LAST = ((s % VAL_BITS) == (VAL_BITS - 1));
    tdor_div_cell #(
      .VAL_BITS (VAL_BITS),
      .N_DIMS   (N_DIMS),
      .DIM      (DIM),
      .LAST     (LAST)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_valid[s]),
      .up_ready (dv_ready[s]),
      .dq_i     (dv_dq[s]),
      .rem_i    (dv_rem[s]),
      .dig_i    (dv_dig[s]),
      .len      (eff_len[DIM]),
      .dn_valid (dv_valid[s+1]),
      .dn_ready (dv_ready[s+1]),
      .dq_o     (dv_dq[s+1]),
      .rem_o    (dv_rem[s+1]),
      .dig_o    (dv_dig[s+1])
    );
  end

  // route selection and join chain
  logic [N_DIMS:0]                        jn_valid;
  logic [N_DIMS:0]                        jn_ready;
  logic [N_DIMS:0][NW-1:0]                jn_acc;
  logic [N_DIMS:0][N_DIMS-1:0][DIG-1:0]   jn_dig;
  tdor_pkg::route_flags_t                 jn_flags [N_DIMS+1];

  tdor_route #(
    .N_DIMS   (N_DIMS),
    .VAL_BITS (VAL_BITS)
  ) u_route (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dv_valid[NUM_DIV]),
    .up_ready (dv_ready[NUM_DIV]),
    .quo_i    (dv_dq[NUM_DIV]),
    .dig_i    (dv_dig[NUM_DIV]),
    .len      (eff_len),
    .dn_valid (jn_valid[0]),
    .dn_ready (jn_ready[0]),
    .dig_o    (jn_dig[0]),
    .flags_o  (jn_flags[0])
  );

  assign jn_acc[0] = '0;

  for (genvar j = 0; j < N_DIMS; j++) begin : g_join
    localparam int DIM = N_DIMS - 1 - j;
    tdor_join_cell #(
      .N_DIMS (N_DIMS),
      .DIM    (DIM)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (jn_valid[j]),
      .up_ready (jn_ready[j]),
      .acc_i    (jn_acc[j]),
      .dig_i    (jn_dig[j]),
      .flags_i  (jn_flags[j]),
      .len      (eff_len[DIM]),
      .dn_valid (jn_valid[j+1]),
      .dn_ready (jn_ready[j+1]),
      .acc_o    (jn_acc[j+1]),
      .dig_o    (jn_dig[j+1]),
      .flags_o  (jn_flags[j+1])
    );
  end

  assign out_ch.valid        = jn_valid[N_DIMS];
  assign jn_ready[N_DIMS]    = out_ch.ready;
  assign out_ch.hop_dim      = jn_flags[N_DIMS].hop_dim;
  assign out_ch.hop_plus     = jn_flags[N_DIMS].hop_plus;
  assign out_ch.arrived      = jn_flags[N_DIMS].arrived;
  assign out_ch.no_route     = jn_flags[N_DIMS].no_route;
  // own node must be rewritten only while idle (not enforced), so the output can read it
  assign out_ch.next_node    = (jn_flags[N_DIMS].arrived || jn_flags[N_DIMS].no_route) ?
                               NW'(own_node_r) : jn_acc[N_DIMS];

  `TDOR_ASSERT_IMP(a_flags_excl, out_ch.valid, !(out_ch.arrived && out_ch.no_route))
  `TDOR_ASSERT_IMP(a_nohop_zero, out_ch.valid && (out_ch.arrived || out_ch.no_route), (out_ch.hop_dim == '0) && !out_ch.hop_plus)
  `TDOR_ASSERT_IMP(a_dim_range, out_ch.valid, out_ch.hop_dim < HDB'(N_DIMS))
  `TDOR_ASSERT_IMP(a_empty_ready, !out_ch.valid, in_ch.ready)
  `TDOR_ASSERT_NEXT(a_first_cell_fill, in_ch.valid && in_ch.ready, dv_valid[1])

endmodule

/* hdl/tdor_div_cell.sv */
module tdor_div_cell #(
  parameter int VAL_BITS = 16,
  parameter int N_DIMS   = 3,
  parameter int DIM      = 0,
  parameter bit LAST     = 1'b0
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   up_valid,
  output logic                                                   up_ready,
  input  logic [1:0][VAL_BITS-1:0]                               dq_i,
  input  logic [1:0][tdor_pkg::DIG_BITS-1:0]                     rem_i,
  input  logic [1:0][N_DIMS-1:0][tdor_pkg::DIG_BITS-1:0]         dig_i,
  input  logic [tdor_pkg::DIG_BITS-1:0]                          len,
  output logic                                                   dn_valid,
  input  logic                                                   dn_ready,
  output logic [1:0][VAL_BITS-1:0]                               dq_o,
  output logic [1:0][tdor_pkg::DIG_BITS-1:0]                     rem_o,
  output logic [1:0][N_DIMS-1:0][tdor_pkg::DIG_BITS-1:0]         dig_o
);

  localparam int DIG = tdor_pkg::DIG_BITS;

  logic                              valid_r;
  logic [1:0][VAL_BITS-1:0]          dq_r, dq_nxt;
  logic [1:0][DIG-1:0]               rem_r, rem_nxt;
  logic [1:0][N_DIMS-1:0][DIG-1:0]   dig_r, dig_nxt;
  logic                              load;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  // one restoring division step on both lanes: lane 0 own node, lane 1 destination
  always_comb begin
    logic [DIG:0] trial;
    logic [DIG:0] diff;
    logic         ge;
    dig_nxt = dig_i;
    dq_nxt  = dq_i;
    rem_nxt = rem_i;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_i[k], dq_i[k][VAL_BITS-1]};
      ge    = (trial >= {1'b0, len});
      diff  = ge ? (trial - {1'b0, len}) : trial;
      dq_nxt[k] = {dq_i[k][VAL_BITS-2:0], ge};
      if (LAST) begin
        // remainder is this dimension's coordinate, quotient feeds the next one
        dig_nxt[k][DIM] = diff[DIG-1:0];
        rem_nxt[k]      = '0;
      end else begin
        rem_nxt[k] = diff[DIG-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
      dig_r <= dig_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dq_o     = dq_r;
  assign rem_o    = rem_r;
  assign dig_o    = dig_r;

endmodule

/* hdl/tdor_route.sv */
module tdor_route #(
  parameter int N_DIMS   = 3,
  parameter int VAL_BITS = 16
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              up_valid,
  output logic                                              up_ready,
  input  logic [1:0][VAL_BITS-1:0]                          quo_i,
  input  logic [1:0][N_DIMS-1:0][tdor_pkg::DIG_BITS-1:0]    dig_i,
  input  logic [N_DIMS-1:0][tdor_pkg::DIG_BITS-1:0]         len,
  output logic                                              dn_valid,
  input  logic                                              dn_ready,
  output logic [N_DIMS-1:0][tdor_pkg::DIG_BITS-1:0]         dig_o,
  output tdor_pkg::route_flags_t                            flags_o
);

  localparam int DIG = tdor_pkg::DIG_BITS;
  localparam int HDB = tdor_pkg::HOP_DIM_BITS;

  logic                            valid_r;
  logic [N_DIMS-1:0][DIG-1:0]      dig_r, dig_nxt;
  tdor_pkg::route_flags_t          flags_r, flags_nxt;
  logic                            load;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  // lowest differing dimension wins; step own coordinate the short way round
  always_comb begin
    logic signed [DIG:0] d_s;
    logic signed [DIG:0] half_s;
    logic [DIG-1:0]      own_c;
    logic [DIG-1:0]      dst_c;
    logic                plus;
    logic                seen;
    seen      = 1'b0;
    flags_nxt = '0;
    dig_nxt   = dig_i[0];
    for (int i = 0; i < N_DIMS; i++) begin
      own_c  = dig_i[0][i];
      dst_c  = dig_i[1][i];
      d_s    = signed'({1'b0, own_c}) - signed'({1'b0, dst_c});
      half_s = signed'({2'b00, len[i][DIG-1:1]});
      plus   = (d_s > half_s) || ((d_s < 0) && (d_s >= -half_s));
      if ((own_c != dst_c) && !seen) begin
        seen               = 1'b1;
        flags_nxt.hop_dim  = HDB'(i);
        flags_nxt.hop_plus = plus;
        if (plus) begin
          dig_nxt[i] = (own_c == len[i] - DIG'(1)) ? '0 : own_c + DIG'(1);
        end else begin
          dig_nxt[i] = (own_c == '0) ? len[i] - DIG'(1) : own_c - DIG'(1);
        end
      end
    end
    // equal digits and equal top quotients means equal numbers
    flags_nxt.arrived  = !seen && (quo_i[0] == quo_i[1]);
    flags_nxt.no_route = !seen && (quo_i[0] != quo_i[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dig_r   <= dig_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dig_o    = dig_r;
  assign flags_o  = flags_r;

endmodule

/* hdl/tdor_join_cell.sv */
module tdor_join_cell #(
  parameter int N_DIMS = 3,
  parameter int DIM    = 0
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          up_valid,
  output logic                                          up_ready,
  input  logic [tdor_pkg::NODE_W-1:0]                   acc_i,
  input  logic [N_DIMS-1:0][tdor_pkg::DIG_BITS-1:0]     dig_i,
  input  tdor_pkg::route_flags_t                        flags_i,
  input  logic [tdor_pkg::DIG_BITS-1:0]                 len,
  output logic                                          dn_valid,
  input  logic                                          dn_ready,
  output logic [tdor_pkg::NODE_W-1:0]                   acc_o,
  output logic [N_DIMS-1:0][tdor_pkg::DIG_BITS-1:0]     dig_o,
  output tdor_pkg::route_flags_t                        flags_o
);

  localparam int NW  = tdor_pkg::NODE_W;
  localparam int DIG = tdor_pkg::DIG_BITS;

  logic                          valid_r;
  logic [NW-1:0]                 acc_r, acc_nxt;
  logic [N_DIMS-1:0][DIG-1:0]    dig_r;
  tdor_pkg::route_flags_t        flags_r;
  logic [NW+DIG-1:0]             prod;
  logic                          load;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  // horner step, highest dimension first, kept modulo the output width
  assign prod    = (NW+DIG)'(acc_i) * (NW+DIG)'(len);
  assign acc_nxt = prod[NW-1:0] + NW'(dig_i[DIM]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r   <= acc_nxt;
      dig_r   <= dig_i;
      flags_r <= flags_i;
    end
  end

  assign dn_valid = valid_r;
  assign acc_o    = acc_r;
  assign dig_o    = dig_r;
  assign flags_o  = flags_r;

endmodule

/* sim/tdor_route_checker.sv */
`timescale 1ns / 100ps

module tdor_route_checker #(
  parameter int N_DIMS    = tdor_pkg::DEF_N_DIMS,
  parameter int NODE_BITS = tdor_pkg::DEF_NODE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tdor_in_if                                   in_ch,
  tdor_out_if                                  out_ch,
  input  logic                                 cfg_we,
  input  logic [tdor_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tdor_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   arrivals,
  output int                                   unroutable
);

  localparam int LEN_REGS = 5;
  localparam int NW       = tdor_pkg::NODE_W;
  localparam int DIG      = tdor_pkg::DIG_BITS;
  localparam int HDB      = tdor_pkg::HOP_DIM_BITS;

  typedef struct packed {
    logic [NW-1:0]          next_node;
    tdor_pkg::route_flags_t flags;
  } hop_result_t;

  logic [NW-1:0]   own_node_q;
  logic [DIG-1:0]  dim_len_q [LEN_REGS];
  hop_result_t     expected_hops [$];

  // next hop for one destination under the current torus setting
  function automatic hop_result_t route_hop(input logic [NW-1:0] dest);
    longint node_mask, own_v, dst_v, half, delta, sum, factor;
    longint lens [LEN_REGS];
    longint oc [LEN_REGS];
    longint dc [LEN_REGS];
    hop_result_t r;
    int i, hit;
    logic plus;
    node_mask = (longint'(1) << NODE_BITS) - 1;
    own_v = longint'(own_node_q) & node_mask;
    dst_v = longint'(dest) & node_mask;
    r = '0;
    r.next_node = own_v[NW-1:0];
    if (own_v == dst_v) begin
      r.flags.arrived = 1'b1;
      return r;
    end
    hit = -1;
    for (i = 0; i < N_DIMS; i++) begin
      // a zero length counts as a ring of one
      lens[i] = (dim_len_q[i] == 0) ? 1 : longint'(dim_len_q[i]);
      oc[i] = own_v % lens[i];
      own_v = own_v / lens[i];
      dc[i] = dst_v % lens[i];
      dst_v = dst_v / lens[i];
      if (hit < 0 && oc[i] != dc[i]) hit = i;
    end
    // numbers differ only in digits above the last dimension
    if (hit < 0) begin
      r.flags.no_route = 1'b1;
      return r;
    end
    delta = oc[hit] - dc[hit];
    half = lens[hit] / 2;
    plus = (delta > half) || (delta < 0 && delta >= -half);
    oc[hit] = plus ? (oc[hit] + 1) % lens[hit] : (oc[hit] + lens[hit] - 1) % lens[hit];
    sum = 0;
    factor = 1;
    for (i = 0; i < N_DIMS; i++) begin
      sum += oc[i] * factor;
      factor *= lens[i];
    end
    r.next_node      = sum[NW-1:0];
    r.flags.hop_dim  = hit[HDB-1:0];
    r.flags.hop_plus = plus;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [NW-1:0] want,
                             input logic [NW-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    hop_result_t hop;
    int i;
    if (!rst_n) begin
      own_node_q <= '0;
      for (i = 0; i < LEN_REGS; i++) dim_len_q[i] <= DIG'(1);
      expected_hops.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tdor_pkg::REG_OWN_NODE) begin
          own_node_q <= cfg_wdata[NW-1:0];
        end else if (cfg_index >= tdor_pkg::REG_DIM_LEN_0 &&
                     cfg_index < tdor_pkg::REG_DIM_LEN_0 + LEN_REGS) begin
          dim_len_q[cfg_index - tdor_pkg::REG_DIM_LEN_0] <= cfg_wdata[DIG-1:0];
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        hop = route_hop(in_ch.dest_node);
        expected_hops.push_back(hop);
        if (hop.flags.arrived) arrivals++;
        if (hop.flags.no_route) unroutable++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hops.size() == 0) begin
          fail_count++;
          $display("%0t: result next_node %0h with no item outstanding", $time,
                   out_ch.next_node);
        end else begin
          hop = expected_hops.pop_front();
          check_field("next_node", hop.next_node, out_ch.next_node);
          check_field("hop_dim", NW'(hop.flags.hop_dim), NW'(out_ch.hop_dim));
          check_field("hop_plus", NW'(hop.flags.hop_plus), NW'(out_ch.hop_plus));
          check_field("arrived", NW'(hop.flags.arrived), NW'(out_ch.arrived));
          check_field("no_route", NW'(hop.flags.no_route), NW'(out_ch.no_route));
        end
      end
      pending <= expected_hops.size();
    end
  end

endmodule

/* sim/torus_dimension_order_route_test.sv */
`timescale 1ns / 100ps

module torus_dimension_order_route_test;

  localparam int NW              = tdor_pkg::NODE_W;
  localparam int DIG             = tdor_pkg::DIG_BITS;
  localparam int CIB             = tdor_pkg::CFG_IDX_BITS;
  localparam int CDB             = tdor_pkg::CFG_DATA_BITS;
  localparam int TB_DIMS         = tdor_pkg::DEF_N_DIMS;
  localparam int TB_NODE_BITS    = tdor_pkg::DEF_NODE_BITS;
  localparam int LEN_REGS        = 5;
  localparam int ROUTE_LATENCY   = TB_DIMS * ((TB_NODE_BITS < 16) ? TB_NODE_BITS : 16)
                                   + 1 + TB_DIMS;
  localparam int RAND_PHASES     = 16;
  localparam int PHASE_ITEMS     = 120;
  localparam int MAX_GAP         = 18;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CIB-1:0]  cfg_index;
  logic [CDB-1:0]  cfg_wdata;

  tdor_in_if  in_ch ();
  tdor_out_if out_ch ();

  int fail_count, pending, arrivals, unroutable;
  int items_sent = 0;
  int settings_done = 0;
  int idle_cycles = 0;
  logic send_idle;
  logic recv_idle;

  logic [NW-1:0]       own_set;
  logic [DIG-1:0]      dim_set [LEN_REGS];
  int                  dim_eff [TB_DIMS];
  int                  own_coord [TB_DIMS];
  longint              torus_size;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  torus_dimension_order_route #(
    .N_DIMS    (TB_DIMS),
    .NODE_BITS (TB_NODE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tdor_route_checker #(
    .N_DIMS    (TB_DIMS),
    .NODE_BITS (TB_NODE_BITS)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .arrivals   (arrivals),
    .unroutable (unroutable)
  );

  function automatic logic [NW-1:0] node_at(input int c0, input int c1, input int c2);
    return NW'(c0 + c1 * dim_eff[0] + c2 * dim_eff[0] * dim_eff[1]);
  endfunction

  task automatic push_dest(input logic [NW-1:0] dest);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.dest_node <= dest;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic drain_routes();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // writes every register while the pipe is empty, plus one write to an unused index
  task automatic apply_setting(input bit pick_own);
    longint rest;
    int i, cap;
    torus_size = 1;
    for (i = 0; i < TB_DIMS; i++) begin
      dim_eff[i] = (dim_set[i] == 0) ? 1 : int'(dim_set[i]);
      torus_size *= dim_eff[i];
    end
    if (pick_own) begin
      cap = (torus_size > 65536) ? 65536 : int'(torus_size);
      own_set = ($urandom_range(0, 3) == 0) ? NW'($urandom) :
                                              NW'($urandom_range(0, cap - 1));
    end
    rest = longint'(own_set);
    for (i = 0; i < TB_DIMS; i++) begin
      own_coord[i] = int'(rest % dim_eff[i]);
      rest = rest / dim_eff[i];
    end
    drain_routes();
    cfg_we    <= 1'b1;
    cfg_index <= tdor_pkg::REG_OWN_NODE;
    cfg_wdata <= own_set;
    @(posedge clk);
    for (i = 0; i < LEN_REGS; i++) begin
      cfg_index <= CIB'(tdor_pkg::REG_DIM_LEN_0 + i);
      // junk above the length field must be dropped
      cfg_wdata <= CDB'(($urandom_range(0, 511) << DIG) | dim_set[i]);
      @(posedge clk);
    end
    cfg_index <= CIB'(tdor_pkg::REG_DIM_LEN_0 + LEN_REGS + $urandom_range(0, 1));
    cfg_wdata <= CDB'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  initial begin : result_sink
    int gap;
    int stall_left;
    out_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
        out_ch.ready <= (gap == 0);
        stall_left = (gap > 0) ? gap - 1 : 0;
      end else if (!out_ch.ready) begin
        if (stall_left <= 0) out_ch.ready <= 1'b1;
        else stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int phase, n, pick, i, j;
    int c [3];
    logic [NW-1:0] dest;
    in_ch.valid     <= 1'b0;
    in_ch.dest_node <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= tdor_pkg::REG_OWN_NODE;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    recv_idle       <= 1'b1;
    send_idle = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // out of reset every ring has length one: node 0 arrives, anything else aliases
    push_dest('0);
    push_dest(16'h0001);
    push_dest('1);

    // own at (4,0,3) on a 5x4x7 torus: both wraps, both half boundaries, each dimension
    own_set = 16'd64;
    {dim_set[0], dim_set[1], dim_set[2], dim_set[3], dim_set[4]} =
      {7'd5, 7'd4, 7'd7, 7'd0, 7'd127};
    apply_setting(1'b0);
    push_dest(node_at(4, 0, 3));
    push_dest(node_at(0, 0, 3));
    push_dest(node_at(1, 0, 3));
    push_dest(node_at(2, 0, 3));
    push_dest(node_at(3, 0, 3));
    push_dest(node_at(4, 1, 3));
    push_dest(node_at(4, 2, 3));
    push_dest(node_at(4, 3, 3));
    push_dest(node_at(4, 0, 0));
    push_dest(node_at(4, 0, 6));
    push_dest(own_set + 16'(torus_size));

    // extreme node and lengths: zero length, lengths above 64, digits dropped on rebuild
    own_set = '1;
    {dim_set[0], dim_set[1], dim_set[2], dim_set[3], dim_set[4]} =
      {7'd0, 7'd127, 7'd127, 7'd127, 7'd0};
    apply_setting(1'b0);
    push_dest('0);
    push_dest('1);
    push_dest(16'h8000);
    push_dest(16'h0001);
    push_dest(16'hFFFE);

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: {dim_set[0], dim_set[1], dim_set[2]} = {7'd8, 7'd8, 7'd8};
        1: {dim_set[0], dim_set[1], dim_set[2]} = {7'd64, 7'd64, 7'd64};
        2: {dim_set[0], dim_set[1], dim_set[2]} = {7'd2, 7'd2, 7'd2};
        3: {dim_set[0], dim_set[1], dim_set[2]} = {7'd1, 7'd1, 7'd1};
        4: {dim_set[0], dim_set[1], dim_set[2]} = {7'd127, 7'd127, 7'd127};
        5: {dim_set[0], dim_set[1], dim_set[2]} = {7'd0, 7'd3, 7'd0};
        default: begin
          for (i = 0; i < TB_DIMS; i++) begin
            pick = $urandom_range(0, 9);
            dim_set[i] = DIG'((pick < 6) ? $urandom_range(2, 12) :
                              (pick < 8) ? $urandom_range(13, 64) :
                              (pick == 8) ? $urandom_range(65, 127) : $urandom_range(0, 1));
          end
        end
      endcase
      dim_set[3] = DIG'($urandom_range(0, 127));
      dim_set[4] = DIG'($urandom_range(0, 127));
      apply_setting(1'b1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          pick = $urandom_range(0, 3);
          send_idle = pick[0];
          recv_idle <= pick[1];
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          dest = own_set;
        end else if (pick < 16) begin
          dest = NW'($urandom);
        end else if (pick < 22) begin
          // same coordinates, different number, unless the sum wraps at 16 bits
          dest = NW'(own_set + torus_size * $urandom_range(1, 3));
        end else begin
          // agree with own below dimension j, differ at j, anything above
          j = $urandom_range(0, TB_DIMS - 1);
          for (i = 0; i < TB_DIMS; i++)
            c[i] = (i < j) ? own_coord[i] : $urandom_range(0, dim_eff[i] - 1);
          if (c[j] == own_coord[j]) c[j] = (c[j] + 1) % dim_eff[j];
          dest = node_at(c[0], c[1], c[2]);
        end
        push_dest(dest);
      end
    end

    drain_routes();
    repeat (ROUTE_LATENCY + 20) @(posedge clk);
    $display("routed %0d destinations over %0d torus settings", items_sent, settings_done);
    $display("%0d of them arrived here, %0d had no route", arrivals, unroutable);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
